// ===== hw/rtl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants
// Payload structs that travel along the square-root and divider cell chains.
// ----------------------------------------------------------------------------
`default_nettype none
package rmq_pkg;

  localparam int FRAC_BITS_DEF = 30;
  localparam int MW            = 32;  // matrix element width
  localparam int DW            = 33;  // off-diagonal sum or difference
  localparam int RW            = 35;  // trace or radicand
  localparam int VW            = 64;  // square-root operand
  localparam int SW            = 32;  // root and quotient width
  localparam int SQ_STEPS      = 32;  // one root bit per cell
  localparam int DV_STEPS      = 32;  // one quotient bit per cell
  localparam int LANES         = 3;

  // Index of the component that comes from the square root.
  localparam logic [1:0] IDX_X = 2'd0;
  localparam logic [1:0] IDX_Y = 2'd1;
  localparam logic [1:0] IDX_Z = 2'd2;
  localparam logic [1:0] IDX_W = 2'd3;

  localparam logic [0:0] REG_TRACE_THRESHOLD = 1'b0;
  localparam logic [30:0] THRESH_RESET = 31'd10737418;

  typedef struct packed {
    logic       vld;
    logic [1:0] sel;
  } ctl_t;

  typedef struct packed {
    ctl_t                 ctl;
    logic [VW-1:0]        v;
    logic [RW-1:0]        rem;
    logic [SW-1:0]        root;
    logic [LANES-1:0][DW-1:0] d;
  } sq_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [SW-1:0] nlo;
    logic [SW-1:0] q;
    logic          neg;
    logic          zero;
    logic          ovf;
  } lane_t;

  typedef struct packed {
    ctl_t                   ctl;
    logic [SW-1:0]          root;
    lane_t [LANES-1:0]      ln;
  } dv_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rmq_front.sv =====
// ----------------------------------------------------------------------------
// rmq_front: branch select and operand setup
// Picks the root component, forms its radicand and the three pair terms.
// ----------------------------------------------------------------------------
`default_nettype none
module rmq_front import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire logic [9*MW-1:0]  mat,
  input  wire logic [30:0]      thresh,
  output sq_t                   q_o
);

  logic signed [RW-1:0] e [9];
  logic signed [RW-1:0] one_c, t, rad_x, rad_y, rad_z, rad;
  logic                 a_gt_b, a_gt_c, b_gt_c, br_w;
  logic [1:0]           sel;
  logic signed [DW-1:0] p01, p02, p12, n12, n20, n01;
  logic [LANES-1:0][DW-1:0] d;
  logic [VW-1:0]        v;
  sq_t                  q_r, q_nxt;

  // Sign-extend the nine elements.
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      e[i] = RW'($signed(mat[i*MW +: MW]));
    end
  end

  // Trace, radicands and branch choice.
  always_comb begin
    one_c  = RW'(1) <<< FRAC_BITS;
    t      = e[0] + e[4] + e[8] + one_c;
    rad_x  = one_c + e[0] - e[4] - e[8];
    rad_y  = one_c + e[4] - e[8] - e[0];
    rad_z  = one_c + e[8] - e[0] - e[4];
    a_gt_b = e[0] > e[4];
    a_gt_c = e[0] > e[8];
    b_gt_c = e[4] > e[8];
    br_w   = t > $signed({4'b0, thresh});
    if (br_w) begin
      sel = IDX_W;
      rad = t;
    end else if (a_gt_b && a_gt_c) begin
      sel = IDX_X;
      rad = rad_x;
    end else if (!a_gt_b && b_gt_c) begin
      sel = IDX_Y;
      rad = rad_y;
    end else begin
      sel = IDX_Z;
      rad = rad_z;
    end
  end

  // Off-diagonal pair terms, ordered as the non-root components.
  always_comb begin
    p01 = DW'(e[1]) + DW'(e[3]);
    p02 = DW'(e[2]) + DW'(e[6]);
    p12 = DW'(e[5]) + DW'(e[7]);
    n12 = DW'(e[5]) - DW'(e[7]);
    n20 = DW'(e[6]) - DW'(e[2]);
    n01 = DW'(e[1]) - DW'(e[3]);
    case (sel)
      IDX_W:   d = {n01, n20, n12};
      IDX_X:   d = {n12, p02, p01};
      IDX_Y:   d = {n20, p12, p01};
      default: d = {n01, p12, p02};
    endcase
  end

  // A negative radicand is clamped to zero.
  always_comb begin
    v = rad[RW-1] ? '0 : (VW'(rad[RW-2:0]) << (FRAC_BITS - 2));
    q_nxt.ctl.vld = in_vld;
    q_nxt.ctl.sel = sel;
    q_nxt.v       = v;
    q_nxt.rem     = '0;
    q_nxt.root    = '0;
    q_nxt.d       = d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.ctl.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule
`default_nettype wire

// ===== hw/rtl/rmq_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// rmq_sqrt_cell: one digit of the square root
// Brings in two operand bits and decides one root bit per cycle while enabled.
// ----------------------------------------------------------------------------
`default_nettype none
module rmq_sqrt_cell import rmq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  sq_t       d_i,
  output sq_t       q_o
);

  logic [RW-1:0] r2, test;
  sq_t           q_r, q_nxt;

  // Trial subtraction of (root * 4 + 1).
  always_comb begin
    r2    = {d_i.rem[RW-3:0], d_i.v[VW-1 -: 2]};
    test  = {1'b0, d_i.root, 2'b01};
    q_nxt = d_i;
    q_nxt.v = d_i.v << 2;
    if (r2 >= test) begin
      q_nxt.rem  = r2 - test;
      q_nxt.root = {d_i.root[SW-2:0], 1'b1};
    end else begin
      q_nxt.rem  = r2;
      q_nxt.root = {d_i.root[SW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.ctl.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule
`default_nettype wire

// ===== hw/rtl/rmq_div_load.sv =====
// ----------------------------------------------------------------------------
// rmq_div_load: divider setup
// Forms magnitudes, shifted dividends and the early overflow test per lane.
// ----------------------------------------------------------------------------
`default_nettype none
module rmq_div_load import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  sq_t       d_i,
  output dv_t       q_o
);

  logic [DW-1:0]   mag [LANES];
  logic [VW-1:0]   num [LANES];
  logic [SW+1:0]   dvs;
  dv_t             q_r, q_nxt;

  always_comb begin
    dvs = {d_i.root, 2'b00};
    q_nxt.ctl  = d_i.ctl;
    q_nxt.root = d_i.root;
    for (int k = 0; k < LANES; k++) begin
      mag[k] = d_i.d[k][DW-1] ? (DW'(0) - d_i.d[k]) : d_i.d[k];
      num[k] = VW'(mag[k]) << FRAC_BITS;
      q_nxt.ln[k].neg  = d_i.d[k][DW-1];
      q_nxt.ln[k].zero = (d_i.d[k] == '0);
      // Quotient would reach 2^32 or the divisor is zero.
      q_nxt.ln[k].ovf  = {2'b00, num[k][VW-1:SW]} >= dvs;
      q_nxt.ln[k].rem  = RW'(num[k][VW-1:SW]);
      q_nxt.ln[k].nlo  = num[k][SW-1:0];
      q_nxt.ln[k].q    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.ctl.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule
`default_nettype wire

// ===== hw/rtl/rmq_div_cell.sv =====
// ----------------------------------------------------------------------------
// rmq_div_cell: one quotient bit for three lanes
// Restoring division step against four times the root component.
// ----------------------------------------------------------------------------
`default_nettype none
module rmq_div_cell import rmq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  dv_t       d_i,
  output dv_t       q_o
);

  logic [RW-1:0] dvs;
  logic [RW-1:0] r2 [LANES];
  dv_t           q_r, q_nxt;

  always_comb begin
    dvs   = {1'b0, d_i.root, 2'b00};
    q_nxt = d_i;
    for (int k = 0; k < LANES; k++) begin
      r2[k] = {d_i.ln[k].rem[RW-2:0], d_i.ln[k].nlo[SW-1]};
      q_nxt.ln[k].nlo = d_i.ln[k].nlo << 1;
      if (r2[k] >= dvs) begin
        q_nxt.ln[k].rem = r2[k] - dvs;
        q_nxt.ln[k].q   = {d_i.ln[k].q[SW-2:0], 1'b1};
      end else begin
        q_nxt.ln[k].rem = r2[k];
        q_nxt.ln[k].q   = {d_i.ln[k].q[SW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.ctl.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule
`default_nettype wire

// ===== hw/rtl/rotation_matrix_to_quaternion_core.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core: 3x3 rotation matrix to unit quaternion
// Fixed-point pipeline: setup, a chain of square-root cells, a chain of
// divider cells for three lanes, saturation, and an output skid register.
//
//   channel  dir  bits  contents
//   in_      in   288   m00..m22, 32 bits each
//   out_     out  128   quat_x, quat_y, quat_z, quat_w
//   cfg_     in   32    trace_threshold at byte address 0
//
// One word is accepted per cycle while the skid register is empty; out_tvalid
// rises once the word has passed the setup stage, 32 root cells, the divider
// load stage, 32 divider cells and the output register.
// Reset clears all valid flags and sets trace_threshold to its default.
// When the output word is stalled, the next word parks in the skid register
// and the pipeline holds until it drains.
// ----------------------------------------------------------------------------
`default_nettype none
module rotation_matrix_to_quaternion_core import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output      logic          in_tready,
  input  wire logic [287:0]  in_tdata,   // m00,m01,m02,m10,m11,m12,m20,m21,m22
  output      logic          out_tvalid,
  input  wire logic          out_tready,
  output      logic [127:0]  out_tdata,  // quat_x, quat_y, quat_z, quat_w
  input  wire logic          cfg_psel,
  input  wire logic          cfg_penable,
  input  wire logic          cfg_pwrite,
  input  wire logic [2:0]    cfg_paddr,
  input  wire logic [31:0]   cfg_pwdata,
  output      logic [31:0]   cfg_prdata,
  output      logic          cfg_pready
);

  logic          en, fire;
  logic [30:0]   thresh_r;
  sq_t           sq [0:SQ_STEPS];
  dv_t           dv [0:DV_STEPS];
  logic [SW-1:0] lv [LANES];
  logic [SW-1:0] comp [4];
  logic [127:0]  res;
  logic          out_vld_r, skid_vld_r;
  logic [127:0]  out_data_r, skid_data_r;

  // Configuration register.
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[2] == REG_TRACE_THRESHOLD) begin
      thresh_r <= cfg_pwdata[30:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == REG_TRACE_THRESHOLD) ? {1'b0, thresh_r} : '0;

  // The pipeline advances whenever the skid register is free.
  assign en        = !skid_vld_r;
  assign in_tready = en;

  rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_tvalid),
    .mat(in_tdata), .thresh(thresh_r), .q_o(sq[0])
  );

  // Square-root cell chain.
  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
    rmq_sqrt_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .d_i(sq[i]), .q_o(sq[i+1])
    );
  end

  rmq_div_load #(.FRAC_BITS(FRAC_BITS)) u_load (
    .clk(clk), .rst_n(rst_n), .en(en), .d_i(sq[SQ_STEPS]), .q_o(dv[0])
  );

  // Divider cell chain.
  for (genvar j = 0; j < DV_STEPS; j++) begin : g_dv
    rmq_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .d_i(dv[j]), .q_o(dv[j+1])
    );
  end

  // Saturate each lane and place components by the root index.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      if (dv[DV_STEPS].ln[k].zero) begin
        lv[k] = '0;
      end else if (dv[DV_STEPS].ln[k].ovf) begin
        lv[k] = dv[DV_STEPS].ln[k].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (dv[DV_STEPS].ln[k].neg) begin
        lv[k] = (dv[DV_STEPS].ln[k].q > 32'h8000_0000) ? 32'h8000_0000
                                                       : (SW'(0) - dv[DV_STEPS].ln[k].q);
      end else begin
        lv[k] = dv[DV_STEPS].ln[k].q[SW-1] ? 32'h7FFF_FFFF : dv[DV_STEPS].ln[k].q;
      end
    end
    for (int c = 0; c < 4; c++) begin
      if (2'(c) == dv[DV_STEPS].ctl.sel) begin
        comp[c] = dv[DV_STEPS].root;
      end else if (2'(c) > dv[DV_STEPS].ctl.sel) begin
        comp[c] = lv[(c > 0) ? c - 1 : 0];
      end else begin
        comp[c] = lv[(c < LANES) ? c : LANES - 1];
      end
    end
    res  = {comp[3], comp[2], comp[1], comp[0]};
    fire = en && dv[DV_STEPS].ctl.vld;
  end

  // Output register with skid word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      if (skid_vld_r) begin
        out_data_r <= skid_data_r;
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_data_r <= res;
        out_vld_r  <= fire;
      end
    end else if (fire) begin
      skid_data_r <= res;
      skid_vld_r  <= 1'b1;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // A parked word always sits behind a shown word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid word held without an output word");

  // A word leaving the chain while the output stalls must park.
  a_park: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && out_vld_r && !out_tready) |=> skid_vld_r)
    else $error("word lost while output stalled");

  // Reset empties both output registers.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_vld_r && !skid_vld_r))
    else $error("output not empty after reset");

endmodule
`default_nettype wire

// ===== tb/tb_rotation_matrix_to_quaternion_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion_core: matrix to quaternion stream check
// Streams directed and random 3x3 matrices through the core under several
// trace thresholds. A behavioral predictor computes each expected quaternion,
// and every output word is compared field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_rotation_matrix_to_quaternion_core import rmq_pkg::*;;

  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = 68;

  typedef struct packed {
    logic signed [31:0] w, z, y, x;
  } quat_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [287:0]  in_tdata = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [127:0]  out_tdata;
  logic          cfg_psel = 1'b0;
  logic          cfg_penable = 1'b0;
  logic          cfg_pwrite = 1'b0;
  logic [2:0]    cfg_paddr = '0;
  logic [31:0]   cfg_pwdata = '0;
  logic [31:0]   cfg_prdata;
  logic          cfg_pready;

  rotation_matrix_to_quaternion_core u_top (.*);

  always #5 clk = ~clk;

  // Predictor copy of the threshold register and the queue of expected words.
  logic [30:0]   thresh_q = THRESH_RESET;
  quat_t         quat_expected[$];
  int            n_errors = 0;
  int            n_words_out = 0;
  int            n_words_in = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint root_comp(longint rad);
    if (rad < 0) rad = 0;
    return clamp32(longint'(int_sqrt(longint'(rad) <<< (FB - 2))));
  endfunction

  function automatic longint quot_comp(longint d, longint s);
    longint unsigned mag, q;
    if (s <= 0) begin
      if (d > 0) return 64'sd2147483647;
      if (d < 0) return -64'sd2147483648;
      return 0;
    end
    mag = (d < 0) ? longint'(-d) : longint'(d);
    mag <<= FB;
    q = mag / (longint'(s) * 4);
    if (d < 0) return (q > 64'h80000000) ? -64'sd2147483648 : -longint'(q);
    return (q > 64'h7fffffff) ? 64'sd2147483647 : longint'(q);
  endfunction

  function automatic quat_t matrix_to_quat(logic [287:0] mat);
    longint m[9];
    longint one, tr;
    longint qx, qy, qz, qw;
    quat_t r;
    for (int i = 0; i < 9; i++) m[i] = longint'($signed(mat[32*i +: 32]));
    one = 64'sd1 << FB;
    tr = m[0] + m[4] + m[8] + one;
    if (tr > longint'({33'd0, thresh_q})) begin
      qw = root_comp(tr);
      qx = quot_comp(m[5] - m[7], qw);
      qy = quot_comp(m[6] - m[2], qw);
      qz = quot_comp(m[1] - m[3], qw);
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      qx = root_comp(one + m[0] - m[4] - m[8]);
      qy = quot_comp(m[3] + m[1], qx);
      qz = quot_comp(m[6] + m[2], qx);
      qw = quot_comp(m[5] - m[7], qx);
    end else if (!(m[0] > m[4]) && m[4] > m[8]) begin
      qy = root_comp(one + m[4] - m[8] - m[0]);
      qx = quot_comp(m[3] + m[1], qy);
      qz = quot_comp(m[7] + m[5], qy);
      qw = quot_comp(m[6] - m[2], qy);
    end else begin
      qz = root_comp(one + m[8] - m[0] - m[4]);
      qx = quot_comp(m[6] + m[2], qz);
      qy = quot_comp(m[7] + m[5], qz);
      qw = quot_comp(m[1] - m[3], qz);
    end
    r.x = qx[31:0];
    r.y = qy[31:0];
    r.z = qz[31:0];
    r.w = qw[31:0];
    return r;
  endfunction

  function automatic logic [287:0] pack_mat(int a0, int a1, int a2, int a3, int a4,
                                            int a5, int a6, int a7, int a8);
    return {a8, a7, a6, a5, a4, a3, a2, a1, a0};
  endfunction

  // Output side: random stalls, and every word checked against the oldest expected.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        quat_t got, exp_q;
        got = out_tdata;
        n_words_out++;
        if (quat_expected.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("ERROR: unexpected output word %h", got);
        end else begin
          exp_q = quat_expected.pop_front();
          if (got !== exp_q) begin
            n_errors++;
            if (n_errors <= 10)
              $display("ERROR: quat mismatch exp x=%h y=%h z=%h w=%h got x=%h y=%h z=%h w=%h",
                       exp_q.x, exp_q.y, exp_q.z, exp_q.w, got.x, got.y, got.z, got.w);
          end
        end
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (stall_left > 0) out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= (stall_left == 0);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Register write over the config port, setup then access phase.
  task automatic write_threshold(logic [30:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {REG_TRACE_THRESHOLD, 2'b00};
    cfg_pwdata <= {1'b0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    thresh_q = value;
  endtask

  // Send one matrix word; the expectation is queued at the accepting edge.
  task automatic send_matrix(logic [287:0] mat, bit check_fixed, quat_t fixed_q);
    int gap;
    quat_t pred;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= mat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = matrix_to_quat(mat);
    if (check_fixed && pred !== fixed_q) begin
      n_errors++;
      if (n_errors <= 10) $display("ERROR: directed row predicted %h, table has %h",
                                   pred, fixed_q);
    end
    quat_expected.push_back(pred);
    n_words_in++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (quat_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Random matrix: mostly elements within +-1.0, some with extremes and raw random bits.
  function automatic logic [287:0] rand_matrix();
    logic [287:0] v;
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      if (kind < 6) v[32*i +: 32] = $signed($urandom_range(0, 32'h80000000)) - 32'sh40000000;
      else if (kind < 8) v[32*i +: 32] = $urandom_range(0, 3) == 0 ?
                                         {$urandom_range(0,1) ? 32'h80000000 : 32'h7fffffff}
                                         : $urandom();
      else v[32*i +: 32] = $urandom();
    end
    return v;
  endfunction

  typedef struct {
    logic [287:0] mat;
    bit           fixed;
    quat_t        q;
  } stim_row_t;

  localparam int ONE = 32'sh40000000;
  localparam int HALF = 32'sh20000000;
  localparam int MAXV = 32'sh7fffffff;
  localparam int MINV = 32'sh80000000;

  stim_row_t dir_rows[$];

  initial begin
    // Identity gives w = 1/2 scaled root of 4, i.e. 1.0.
    dir_rows.push_back('{pack_mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1,
                         '{w: ONE, z: 0, y: 0, x: 0}});
    // Half-turns about each axis go through the x, y and z branches.
    dir_rows.push_back('{pack_mat(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE), 1,
                         '{w: 0, z: 0, y: 0, x: ONE}});
    dir_rows.push_back('{pack_mat(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE), 1,
                         '{w: 0, z: 0, y: ONE, x: 0}});
    dir_rows.push_back('{pack_mat(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE), 1,
                         '{w: 0, z: 0, y: 0, x: 0}});
    dir_rows[$].q.z = ONE;
    // All zero: trace+1 = 1 takes the w branch.
    dir_rows.push_back('{pack_mat(0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         '{w: HALF, z: 0, y: 0, x: 0}});
    // Extremes in the z branch with a large radicand, predictor only.
    dir_rows.push_back('{pack_mat(MINV, ONE, MAXV, 0, MINV, 0, MINV, MAXV, MINV), 0, '0});
    // Equal diagonal ties and mixed extremes, predictor only.
    dir_rows.push_back('{pack_mat(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV),
                         0, '0});
    dir_rows.push_back('{pack_mat(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV),
                         0, '0});
    dir_rows.push_back('{pack_mat(-ONE, MAXV, MINV, MINV, -ONE, MAXV, MAXV, MINV, -ONE),
                         0, '0});
    dir_rows.push_back('{pack_mat(MAXV, 1, -1, 5, MINV, MINV, 3, MAXV, MINV), 0, '0});
    dir_rows.push_back('{pack_mat(MINV, 7, 9, -3, MAXV, 1, 2, 3, MINV), 0, '0});
    dir_rows.push_back('{pack_mat(-HALF, HALF, HALF, -HALF, -HALF, HALF, 0, 0, -HALF),
                         0, '0});
    dir_rows.push_back('{pack_mat(0, ONE, 0, -ONE, 0, 0, 0, 0, ONE), 0, '0});
    dir_rows.push_back('{pack_mat(-1, -1, -1, -1, -1, -1, -1, -1, -1), 0, '0});
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at the reset threshold.
    foreach (dir_rows[i]) send_matrix(dir_rows[i].mat, dir_rows[i].fixed, dir_rows[i].q);
    drain();

    // Random phases under several thresholds, extremes included.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_threshold(31'd0);
        1: write_threshold(31'h40000000);
        2: write_threshold(31'h7fffffff);
        3: write_threshold(31'($urandom_range(0, 32'h40000000)));
        default: write_threshold(THRESH_RESET);
      endcase
      for (int k = 0; k < 110; k++) begin
        send_matrix(rand_matrix(), 0, '0);
        // Back-pressure hold-off: sender waits for the pipeline to empty.
        if (k == 50) begin
          in_tvalid <= 1'b0;
          while (quat_expected.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("Sent %0d matrices over six threshold settings; %0d quaternions checked.",
             n_words_in, n_words_out);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout waiting for output words");
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
